FILE: hw/rtl/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and constants for the UTF-8 stream decoder and validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  // default width of the per-string character counter
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CP_W    = 21;
  localparam int ACC_W   = 31;
  localparam int TOTAL_W = 16;

  // input tdata is one byte, output tdata holds code point and total
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 3;

  // sequence lengths
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_1    = 3'd1;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;
  localparam logic [2:0] LEN_5    = 3'd5;
  localparam logic [2:0] LEN_6    = 3'd6;

  // decoder state carried between bytes (counter kept apart, its width varies)
  typedef struct packed {
    logic [2:0]       bytes_rem;
    logic [2:0]       seq_len;
    logic [ACC_W-1:0] acc;
    logic             err_seen;
  } dec_state_t;

  // one result transaction
  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic               char_ready;
    logic               decode_error;
    logic               string_done;
    logic               string_valid;
    logic [TOTAL_W-1:0] char_total;
  } dec_result_t;

  // shortest form length able to carry a value
  function automatic logic [2:0] form_length(input logic [ACC_W-1:0] v);
    logic [2:0] len;
    if (v < 31'h80)           len = LEN_1;
    else if (v < 31'h800)     len = LEN_2;
    else if (v < 31'h10000)   len = LEN_3;
    else if (v < 31'h200000)  len = LEN_4;
    else if (v < 31'h4000000) len = LEN_5;
    else                      len = LEN_6;
    return len;
  endfunction

  // valid unicode scalar that is not a noncharacter
  function automatic logic scalar_ok(input logic [ACC_W-1:0] v);
    logic in_range;
    logic surrogate;
    logic nonchar_blk;
    logic nonchar_end;
    in_range    = (v < 31'h110000);
    surrogate   = (v[ACC_W-1:11] == 20'h0001B);
    nonchar_blk = (v >= 31'hFDD0) && (v <= 31'hFDEF);
    nonchar_end = (v[15:1] == 15'h7FFF);
    return in_range && !surrogate && !nonchar_blk && !nonchar_end;
  endfunction

endpackage

FILE: hw/rtl/utf8v_decode.sv
// ----------------------------------------------------------------------------
// utf8v_decode
// Single-byte decode step: lead/continuation handling, value checks,
// counter update and result formation.
// ----------------------------------------------------------------------------
module utf8v_decode
  import utf8v_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  dec_state_t             state,
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_string,
  output dec_state_t             state_nxt,
  output logic [COUNT_WIDTH-1:0] count_nxt,
  output logic                   has_result,
  output dec_result_t            result
);

  dec_state_t             st;
  logic                   ready;
  logic                   err;
  logic [CP_W-1:0]        cp;
  logic [ACC_W-1:0]       acc_new;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH+TOTAL_W-1:0] cnt_ext;

  // byte decode and state update
  always_comb begin
    st      = state;
    ready   = 1'b0;
    err     = 1'b0;
    cp      = '0;
    acc_new = {state.acc[ACC_W-7:0], data_byte[5:0]};
    cnt     = count;
    if (!state.err_seen) begin
      if (state.bytes_rem == 3'd0) begin
        // lead byte expected
        if (data_byte < 8'h80) begin
          ready = 1'b1;
          cp    = CP_W'(data_byte);
        end else if (data_byte < 8'hC0) begin
          err = 1'b1;
        end else if (data_byte < 8'hE0) begin
          st.seq_len = LEN_2; st.bytes_rem = 3'd1; st.acc = ACC_W'(data_byte[4:0]);
        end else if (data_byte < 8'hF0) begin
          st.seq_len = LEN_3; st.bytes_rem = 3'd2; st.acc = ACC_W'(data_byte[3:0]);
        end else if (data_byte < 8'hF8) begin
          st.seq_len = LEN_4; st.bytes_rem = 3'd3; st.acc = ACC_W'(data_byte[2:0]);
        end else if (data_byte < 8'hFC) begin
          st.seq_len = LEN_5; st.bytes_rem = 3'd4; st.acc = ACC_W'(data_byte[1:0]);
        end else if (data_byte < 8'hFE) begin
          st.seq_len = LEN_6; st.bytes_rem = 3'd5; st.acc = ACC_W'(data_byte[0]);
        end else begin
          err = 1'b1;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        // missing continuation
        err = 1'b1;
      end else begin
        // continuation: shift in six bits, check on the last one
        st.acc       = acc_new;
        st.bytes_rem = state.bytes_rem - 3'd1;
        if (st.bytes_rem == 3'd0) begin
          if ((form_length(acc_new) == state.seq_len) && scalar_ok(acc_new)) begin
            ready = 1'b1;
            cp    = acc_new[CP_W-1:0];
          end else begin
            err = 1'b1;
          end
        end
      end
      // truncated sequence at end of string
      if (!err && end_of_string && (st.bytes_rem != 3'd0)) begin
        err = 1'b1;
      end
      // saturating character count
      if (ready && (count != {COUNT_WIDTH{1'b1}})) begin
        cnt = count + COUNT_WIDTH'(1);
      end
      if (err) begin
        st.err_seen  = 1'b1;
        st.bytes_rem = 3'd0;
      end
    end
  end

  // clamp the count to the reported width
  assign cnt_ext = (COUNT_WIDTH+TOTAL_W)'(cnt);

  // result fields
  always_comb begin
    result.code_point   = cp;
    result.char_ready   = ready;
    result.decode_error = err;
    result.string_done  = end_of_string;
    result.string_valid = end_of_string && !st.err_seen;
    result.char_total   = (|cnt_ext[COUNT_WIDTH+TOTAL_W-1:TOTAL_W]) ?
                          {TOTAL_W{1'b1}} : cnt_ext[TOTAL_W-1:0];
  end

  assign has_result = ready || err || end_of_string;

  // a string end returns everything to zero
  assign state_nxt = end_of_string ? '0 : st;
  assign count_nxt = end_of_string ? '0 : cnt;

endmodule

FILE: hw/rtl/utf8_stream_decoder_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_validator
// UTF-8 stream decoder with validation, one byte per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one byte per transaction in in_tdata, in_tlast set on
//   the final byte of a string. Output channel out_*: one transaction when a
//   character completes, when the first error of a string is found, or on
//   the final byte of a string (out_tlast set, with validity and count).
//   Bytes that complete nothing produce no output transaction.
//   A byte accepted into the input register is decoded from there into the
//   output register when it advances, so its result is on out_* once the
//   output register has room.
//   Throughput: one byte per cycle while the output is not stalled, limited
//   by the single decode step between the input register and the output
//   register; the per-string decoder state updates each cycle a byte leaves the input register.
//   Stall: while out_tready is low and a result is held, a byte that has a
//   result waits in the input register and in_tready drops; bytes without a
//   result still pass.
//   Reset: rst_n low clears both registers' valid flags and the decoder
//   state; the first byte after reset starts a new string.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_validator
  import utf8v_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input byte stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // end_of_string
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [20:0] code_point, [36:21] char_total, [39:37] zero
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [0] char_ready, [1] decode_error, [2] string_valid
  output logic                   out_tlast   // string_done
);

  logic                   in_valid_r;
  logic [7:0]             in_byte_r;
  logic                   in_last_r;
  logic                   out_valid_r;
  dec_result_t            out_res_r;
  dec_state_t             state_r;
  dec_state_t             state_nxt;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic                   has_result;
  dec_result_t            result;
  logic                   advance;

  // decode step
  utf8v_decode #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_decode (
    .state         (state_r),
    .count         (count_r),
    .data_byte     (in_byte_r),
    .end_of_string (in_last_r),
    .state_nxt     (state_nxt),
    .count_nxt     (count_nxt),
    .has_result    (has_result),
    .result        (result)
  );

  // byte leaves the input register when it has no result or its result has room
  assign advance   = in_valid_r && (!has_result || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      count_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_res_r <= result;
    end
  end

  // port packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.char_total, out_res_r.code_point};
  assign out_tuser  = {out_res_r.string_valid, out_res_r.decode_error,
                       out_res_r.char_ready};
  assign out_tlast  = out_res_r.string_done;

endmodule

FILE: hw/rtl/utf8v_checker.sv
// ----------------------------------------------------------------------------
// utf8v_checker
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8v_checker
  import utf8v_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser,
  input logic                   out_tlast
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // string valid only on a string's final result
  a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast && !out_tuser[1])
    else $error("string_valid without string_done or with error");

  // a character and an error never share a result
  a_char_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1])
    else $error("char_ready and decode_error together");

  // decoded characters stay in the unicode range
  a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[CP_W-1:0] < 21'h110000)
    else $error("code point out of range");

endmodule

bind utf8_stream_decoder_validator utf8v_checker u_utf8v_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: bench/utf8_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_checker
// Watches both streams of the UTF-8 decoder. Every accepted byte is run
// through a local decoder model, and the result transactions it calls for are
// queued. Every accepted result transaction is compared field by field with
// the oldest queued one.
// ----------------------------------------------------------------------------
module utf8_checker
  import utf8v_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // end_of_string
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [20:0] code_point, [36:21] char_total
  input  logic [OUT_TUSER_W-1:0] out_tuser,  // [0] char_ready, [1] decode_error, [2] string_valid
  input  logic                   out_tlast,  // string_done
  output int                     fail_count,
  output int                     results_due
);

  dec_result_t due_results[$];
  int          miss_count;

  // decoder model state
  logic [2:0]                 cont_left;
  logic [2:0]                 form_len;
  logic [ACC_W-1:0]           cp_acc;
  logic                       bad_seen;
  logic [COUNT_WIDTH_DEF-1:0] char_cnt;

  // shortest encoding length, from the highest populated payload group
  function automatic logic [2:0] shortest_form(input logic [ACC_W-1:0] v);
    logic [2:0] n;
    if (v[30:26] != '0)      n = LEN_6;
    else if (v[25:21] != '0) n = LEN_5;
    else if (v[20:16] != '0) n = LEN_4;
    else if (v[15:11] != '0) n = LEN_3;
    else if (v[10:7] != '0)  n = LEN_2;
    else                     n = LEN_1;
    return n;
  endfunction

  // unicode scalar, no surrogate, no noncharacter
  function automatic logic legal_scalar(input logic [ACC_W-1:0] v);
    logic ok;
    ok = (v <= 31'h10FFFF);
    if (v >= 31'hD800 && v <= 31'hDFFF) ok = 1'b0;
    if (v >= 31'hFDD0 && v <= 31'hFDEF) ok = 1'b0;
    if (v[15:0] >= 16'hFFFE) ok = 1'b0;
    return ok;
  endfunction

  // advance the model by one byte and queue the result it produces, if any
  task automatic decode_byte(input logic [7:0] b, input logic last);
    dec_result_t r;
    logic        ready;
    logic        err;
    logic [2:0]  n;
    logic [ACC_W-1:0] cp;
    ready = 1'b0;
    err   = 1'b0;
    n     = LEN_NONE;
    cp    = '0;
    if (!bad_seen) begin
      if (cont_left == 3'd0) begin
        // lead byte expected
        if (b < 8'h80) begin
          ready = 1'b1;
          cp    = ACC_W'(b);
        end else if (b < 8'hC0 || b >= 8'hFE) begin
          err = 1'b1;
        end else begin
          if (b < 8'hE0)      n = LEN_2;
          else if (b < 8'hF0) n = LEN_3;
          else if (b < 8'hF8) n = LEN_4;
          else if (b < 8'hFC) n = LEN_5;
          else                n = LEN_6;
          form_len  = n;
          cont_left = n - 3'd1;
          cp_acc    = ACC_W'(b & (8'hFF >> (n + 3'd1)));
        end
      end else if (b[7:6] != 2'b10) begin
        // missing continuation, not decoded again as a lead
        err = 1'b1;
      end else begin
        cp_acc    = {cp_acc[ACC_W-7:0], b[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == 3'd0) begin
          if (shortest_form(cp_acc) == form_len && legal_scalar(cp_acc)) begin
            ready = 1'b1;
            cp    = cp_acc;
          end else begin
            err = 1'b1;
          end
        end
      end
      // string cut off mid-sequence
      if (!err && last && cont_left != 3'd0) err = 1'b1;
      if (ready && char_cnt != '1) char_cnt = char_cnt + 1'b1;
      if (err) begin
        bad_seen  = 1'b1;
        cont_left = 3'd0;
      end
    end
    if (ready || err || last) begin
      r.code_point   = ready ? cp[CP_W-1:0] : '0;
      r.char_ready   = ready;
      r.decode_error = err;
      r.string_done  = last;
      r.string_valid = last && !bad_seen;
      r.char_total   = char_cnt[TOTAL_W-1:0];
      due_results.push_back(r);
    end
    if (last) begin
      cont_left = 3'd0;
      form_len  = LEN_NONE;
      cp_acc    = '0;
      bad_seen  = 1'b0;
      char_cnt  = '0;
    end
  endtask

  // compare one result transaction with the oldest expectation
  task automatic check_result();
    dec_result_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result transaction: tdata %0h tuser %0b tlast %0b",
             out_tdata, out_tuser, out_tlast);
      miss_count++;
    end else begin
      want = due_results.pop_front();
      if (out_tdata[CP_W-1:0] !== want.code_point) begin
        $error("code_point: expected %0h, got %0h", want.code_point, out_tdata[CP_W-1:0]);
        miss_count++;
      end
      if (out_tuser[0] !== want.char_ready) begin
        $error("char_ready: expected %0b, got %0b", want.char_ready, out_tuser[0]);
        miss_count++;
      end
      if (out_tuser[1] !== want.decode_error) begin
        $error("decode_error: expected %0b, got %0b", want.decode_error, out_tuser[1]);
        miss_count++;
      end
      if (out_tlast !== want.string_done) begin
        $error("string_done: expected %0b, got %0b", want.string_done, out_tlast);
        miss_count++;
      end
      if (out_tuser[2] !== want.string_valid) begin
        $error("string_valid: expected %0b, got %0b", want.string_valid, out_tuser[2]);
        miss_count++;
      end
      if (out_tdata[CP_W+TOTAL_W-1:CP_W] !== want.char_total) begin
        $error("char_total: expected %0d, got %0d", want.char_total,
               out_tdata[CP_W+TOTAL_W-1:CP_W]);
        miss_count++;
      end
      if (out_tdata[OUT_TDATA_W-1:CP_W+TOTAL_W] !== '0) begin
        $error("tdata padding: expected 0, got %0h", out_tdata[OUT_TDATA_W-1:CP_W+TOTAL_W]);
        miss_count++;
      end
    end
  endtask

  // monitor both channels
  always @(posedge clk) begin
    if (!rst_n) begin
      due_results.delete();
      miss_count = 0;
      cont_left  = 3'd0;
      form_len   = LEN_NONE;
      cp_acc     = '0;
      bad_seen   = 1'b0;
      char_cnt   = '0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) decode_byte(in_tdata[7:0], in_tlast);
    end
    fail_count  <= miss_count;
    results_due <= due_results.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the UTF-8 decoder bench. Sends a short set of hand-made strings
// covering 1-, 2- and 4-byte forms and most rejection rules, then random
// strings built mostly from well-formed sequences with some broken ones. The
// sender idles in bursts, the receiver stalls on its own pattern, and the
// checker instance does all the prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  import utf8v_pkg::*;

  localparam int DIRECTED_LEN   = 26;
  localparam int RANDOM_BYTES   = 1850;
  localparam int WATCHDOG_LIMIT = 2000;

  // receiver stall modes
  localparam int RX_OPEN     = 0;
  localparam int RX_LIGHT    = 1;
  localparam int RX_HEAVY    = 2;
  localparam int RX_PERIODIC = 3;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [7:0] data_byte
  logic                   in_tlast;   // end_of_string
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [20:0] code_point, [36:21] char_total
  logic [OUT_TUSER_W-1:0] out_tuser;  // [0] char_ready, [1] decode_error, [2] string_valid
  logic                   out_tlast;  // string_done

  int fail_count;
  int results_due;
  int burst_left = 0;
  int bytes_sent = 0;
  int stuck_cycles = 0;
  int rx_mode = RX_OPEN;
  int rx_phase_left = 0;
  int unsigned rx_tick = 0;

  logic [7:0] str_bytes[$];

  // hand-made strings, bit 8 marks the final byte
  logic [8:0] directed [DIRECTED_LEN] = '{
    9'h100,                                 // lone NUL
    9'h07F, 9'h0C2, 9'h080, 9'h0DF, 9'h1BF, // 1- and 2-byte extremes
    9'h180,                                 // stray continuation
    9'h0FE, 9'h1FF,                         // bad lead, then ignored byte
    9'h1FF,                                 // bad lead on the final byte
    9'h0C0, 9'h180,                         // overlong
    9'h0ED, 9'h0A0, 9'h180,                 // surrogate
    9'h0EF, 9'h0B7, 9'h190,                 // noncharacter block
    9'h0C2, 9'h141,                         // missing continuation
    9'h0E2, 9'h182,                         // truncated string
    9'h0F0, 9'h090, 9'h080, 9'h180          // first 4-byte code point
  };

  always #5 clk = ~clk;

  utf8_stream_decoder_validator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  utf8_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // receiver backpressure, mode picked anew at the end of each random-length phase
  always @(posedge clk) begin
    rx_tick++;
    if (rx_phase_left == 0) begin
      rx_mode       = $urandom_range(RX_OPEN, RX_PERIODIC);
      rx_phase_left = $urandom_range(50, 300);
    end
    rx_phase_left--;
    case (rx_mode)
      RX_OPEN:  out_tready <= 1'b1;
      RX_LIGHT: out_tready <= ($urandom_range(0, 9) < 7);
      RX_HEAVY: out_tready <= ($urandom_range(0, 9) < 3);
      default:  out_tready <= (rx_tick[2:0] < 3'd5);
    endcase
  end

  // watchdog on cycles without any transaction while work is outstanding
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (in_tvalid || results_due != 0) begin
      stuck_cycles <= stuck_cycles + 1;
    end else begin
      stuck_cycles <= 0;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one byte transaction, with a random gap at the start of each burst
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // append the n-byte form of v, overlong when n exceeds the shortest form
  task automatic put_seq(input logic [30:0] v, input int n);
    logic [7:0]  lead;
    logic [30:0] top;
    if (n == 1) begin
      str_bytes.push_back({1'b0, v[6:0]});
    end else begin
      top  = v >> (6 * (n - 1));
      lead = 8'hFF << (8 - n);
      lead = lead | (top[7:0] & (8'hFF >> (n + 1)));
      str_bytes.push_back(lead);
      for (int k = n - 2; k >= 0; k--) begin
        top = v >> (6 * k);
        str_bytes.push_back({2'b10, top[5:0]});
      end
    end
  endtask

  // code point of random class, n is its natural length
  task automatic pick_char(output logic [30:0] v, output int n);
    logic [30:0] edge_cp [16] = '{
      31'hD7FF, 31'hD800, 31'hDFFF, 31'hE000, 31'hFDCF, 31'hFDD0, 31'hFDEF, 31'hFDF0,
      31'hFFFD, 31'hFFFE, 31'hFFFF, 31'h1FFFE, 31'h10FFFD, 31'h10FFFF, 31'h110000,
      31'h10000
    };
    case ($urandom_range(0, 11))
      0, 1, 2: begin n = 1; v = $urandom_range(0, 31'h7F); end
      3, 4:    begin n = 2; v = $urandom_range(31'h80, 31'h7FF); end
      5, 6:    begin n = 3; v = $urandom_range(31'h800, 31'hFFFF); end
      7, 8:    begin n = 4; v = $urandom_range(31'h10000, 31'h10FFFF); end
      9: begin
        v = edge_cp[$urandom_range(0, 15)];
        n = (v > 31'hFFFF) ? 4 : 3;
      end
      10: begin
        n = $urandom_range(4, 6);
        if (n == 4)      v = $urandom_range(31'h110000, 31'h1FFFFF);
        else if (n == 5) v = $urandom_range(31'h200000, 31'h3FFFFFF);
        else             v = $urandom_range(31'h4000000, 31'h7FFFFFFF);
      end
      default: begin n = 1; v = $urandom_range(0, 31'h7F); end
    endcase
  endtask

  // random string: mostly clean sequences, some broken ones
  task automatic build_string();
    logic [30:0] v;
    int n;
    int kind;
    str_bytes.delete();
    repeat ($urandom_range(1, 8)) begin
      pick_char(v, n);
      kind = $urandom_range(0, 99);
      if (kind < 88) begin
        put_seq(v, n);
      end else if (kind < 90) begin
        str_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
      end else if (kind < 92) begin
        str_bytes.push_back($urandom_range(0, 1) ? 8'hFE : 8'hFF);
      end else if (kind < 95) begin
        // sequence broken by a byte that is no continuation
        put_seq(v, n);
        if (n > 1) begin
          void'(str_bytes.pop_back());
          str_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                                   : 8'($urandom_range(8'hC0, 8'hFF)));
        end
      end else if (kind < 98) begin
        put_seq(v, (n < 6) ? n + 1 : n);
      end else begin
        str_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    // now and then the string ends inside a sequence
    if ($urandom_range(0, 11) == 0) begin
      put_seq(31'($urandom_range(31'h80, 31'h10FFFF)), $urandom_range(2, 4));
      void'(str_bytes.pop_back());
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);

    while (bytes_sent < DIRECTED_LEN + RANDOM_BYTES) begin
      build_string();
      foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
    end
    in_tvalid <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    do @(posedge clk); while (results_due != 0);
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
